### design/cda_pkg.sv
// Package for the calendar date adder: types, constants, microcode table and calendar helpers.
`timescale 1ns / 1ps

package cda_pkg;

    typedef logic [3:0] pc_t;

    localparam pc_t P_IDLE  = 4'd0;
    localparam pc_t P_DMUL  = 4'd1;
    localparam pc_t P_DMOD  = 4'd2;
    localparam pc_t P_DYEAR = 4'd3;
    localparam pc_t P_DMON  = 4'd4;
    localparam pc_t P_DADD  = 4'd5;
    localparam pc_t P_DFIX  = 4'd6;
    localparam pc_t P_MMUL  = 4'd7;
    localparam pc_t P_MADD  = 4'd8;
    localparam pc_t P_MFIX  = 4'd9;
    localparam pc_t P_YADD  = 4'd10;
    localparam pc_t P_DONE  = 4'd11;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_YMUL,
        OP_YMOD,
        OP_YSTEP,
        OP_MSTEP,
        OP_DAYADD,
        OP_DAYFIX,
        OP_AMUL,
        OP_MADD,
        OP_MFIX,
        OP_YADD,
        OP_FINISH
    } op_t;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_WAIT_IN,
        SEQ_LOOP,
        SEQ_WAIT_OUT
    } seq_t;

    typedef enum logic [1:0] {
        ACT_DAYS,
        ACT_MONTHS,
        ACT_YEARS,
        ACT_NONE
    } action_t;

    typedef struct packed {
        op_t  op;
        seq_t seq;
        pc_t  target;
    } uword_t;

    localparam logic [13:0] YEAR_MAX        = 14'd9999;
    localparam logic [8:0]  YEAR_LEN        = 9'd365;
    localparam logic [8:0]  LEAP_CYCLE      = 9'd400;
    localparam logic [4:0]  MONTHS_PER_YEAR = 5'd12;
    localparam logic [12:0] RECIP_400       = 13'd5243;
    localparam int          RECIP_400_SHIFT = 21;
    localparam logic [15:0] RECIP_12        = 16'd43691;
    localparam int          RECIP_12_SHIFT  = 19;

    function automatic uword_t ucode_rom(input pc_t pc);
        uword_t w;
        case (pc)
            P_IDLE:  w = '{op: OP_LOAD,   seq: SEQ_WAIT_IN,  target: P_IDLE};
            P_DMUL:  w = '{op: OP_YMUL,   seq: SEQ_NEXT,     target: P_IDLE};
            P_DMOD:  w = '{op: OP_YMOD,   seq: SEQ_NEXT,     target: P_IDLE};
            P_DYEAR: w = '{op: OP_YSTEP,  seq: SEQ_LOOP,     target: P_IDLE};
            P_DMON:  w = '{op: OP_MSTEP,  seq: SEQ_LOOP,     target: P_IDLE};
            P_DADD:  w = '{op: OP_DAYADD, seq: SEQ_NEXT,     target: P_IDLE};
            P_DFIX:  w = '{op: OP_DAYFIX, seq: SEQ_JUMP,     target: P_DONE};
            P_MMUL:  w = '{op: OP_AMUL,   seq: SEQ_NEXT,     target: P_IDLE};
            P_MADD:  w = '{op: OP_MADD,   seq: SEQ_NEXT,     target: P_IDLE};
            P_MFIX:  w = '{op: OP_MFIX,   seq: SEQ_JUMP,     target: P_DONE};
            P_YADD:  w = '{op: OP_YADD,   seq: SEQ_JUMP,     target: P_DONE};
            P_DONE:  w = '{op: OP_FINISH, seq: SEQ_WAIT_OUT, target: P_IDLE};
            default: w = '{op: OP_NOP,    seq: SEQ_JUMP,     target: P_IDLE};
        endcase
        return w;
    endfunction

    function automatic pc_t dispatch(input action_t act);
        pc_t p;
        case (act)
            ACT_DAYS:   p = P_DMUL;
            ACT_MONTHS: p = P_MMUL;
            ACT_YEARS:  p = P_YADD;
            default:    p = P_DONE;
        endcase
        return p;
    endfunction

    // Leap test on a year given modulo 400.
    function automatic logic is_leap(input logic [8:0] r);
        return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

    function automatic logic [4:0] month_len(input logic [4:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            5'd2:    len = leap ? 5'd29 : 5'd28;
            5'd4:    len = 5'd30;
            5'd6:    len = 5'd30;
            5'd9:    len = 5'd30;
            5'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### design/calendar_date_adder.sv
// Calendar date adder: adds days, months or years to a Gregorian date under microcode control.
//
// The input channel (s_) carries one request per transfer: the action in s_tuser and the
// starting date and amount in s_tdata. The result channel (m_) returns one date per request,
// with the year overflow flag in m_tuser. Years above 9999 saturate and set that flag.
// A request is accepted only while the sequencer sits in its idle step, so one request is
// worked at a time; each request runs a short program from the microcode table.
// Steps from input transfer to result valid:
//   add days:   reciprocal multiply, year modulo 400, a loop over whole years and one over
//               whole months consumed, one per cycle by subtract and compare, day add, day
//               fix, output load.
//   add months: reciprocal multiply, add, wrap fix, output load.
//   add years:  year add, output load.  Unused action code: output load only.
// The sequencer then returns to its idle step before the next request is taken.
// The result is held in an output register, so a new request is accepted while a result
// still waits; a stalled receiver holds the sequencer in its final step only when a second
// result is ready. After reset the sequencer is idle and no result is valid.
`timescale 1ns / 1ps

module calendar_date_adder
    import cda_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: start_day[4:0], start_month[3:0], start_year[13:0], amount[15:0],
    // one zero pad bit.
    input  logic [39:0] s_tdata,
    // Fields from bit 0: action[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: new_day[4:0], new_month[3:0], new_year[13:0], one zero pad bit.
    output logic [23:0] m_tdata,
    // Fields from bit 0: year_overflow.
    output logic [0:0]  m_tuser
);

    pc_t         pc_reg, pc_next;
    logic [16:0] year_reg, year_next;
    logic [4:0]  month_reg, month_next;
    logic [5:0]  day_reg, day_next;
    logic [15:0] amt_reg, amt_next;
    logic [8:0]  yr400_reg, yr400_next;
    logic [31:0] prod_reg, prod_next;
    logic [4:0]  out_day_reg, out_day_next;
    logic [3:0]  out_month_reg, out_month_next;
    logic [13:0] out_year_reg, out_year_next;
    logic        out_ovf_reg, out_ovf_next;
    logic        m_tvalid_reg, m_tvalid_next;

    uword_t      uw;
    logic        s_accept;
    logic        out_free;
    logic [8:0]  yr400_inc;
    logic [8:0]  year_len;
    logic [4:0]  cur_mlen;
    logic        year_fits;
    logic        month_fits;
    logic        loop_cond;
    logic        month_wrap;
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [5:0]  q400;
    logic [13:0] q400_x;
    logic [13:0] yr_rem;
    logic [12:0] q12;
    logic [15:0] q12_x;
    logic [15:0] mon_rem;
    logic        sat;

    assign uw       = ucode_rom(pc_reg);
    assign s_tready = (pc_reg == P_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign yr400_inc  = (yr400_reg == LEAP_CYCLE - 9'd1) ? 9'd0 : yr400_reg + 9'd1;
    assign year_len   = is_leap(yr400_inc) ? YEAR_LEN + 9'd1 : YEAR_LEN;
    assign cur_mlen   = month_len(month_reg, is_leap(yr400_reg));
    assign year_fits  = amt_reg >= {7'd0, year_len};
    assign month_fits = amt_reg >= {11'd0, cur_mlen};
    assign month_wrap = month_reg >= MONTHS_PER_YEAR;

    assign mul_a = (uw.op == OP_YMUL) ? {2'b00, year_reg[13:0]} : amt_reg;
    assign mul_b = (uw.op == OP_YMUL) ? {3'b000, RECIP_400} : RECIP_12;

    assign q400    = prod_reg[RECIP_400_SHIFT+5:RECIP_400_SHIFT];
    assign q400_x  = {q400, 8'd0} + {1'b0, q400, 7'd0} + {4'd0, q400, 4'd0};
    assign yr_rem  = year_reg[13:0] - q400_x;
    assign q12     = prod_reg[RECIP_12_SHIFT+12:RECIP_12_SHIFT];
    assign q12_x   = {q12, 3'd0} + {1'b0, q12, 2'd0};
    assign mon_rem = amt_reg - q12_x;

    assign sat = year_reg > {3'd0, YEAR_MAX};

    always_comb begin
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        amt_next       = amt_reg;
        yr400_next     = yr400_reg;
        prod_next      = prod_reg;
        out_day_next   = out_day_reg;
        out_month_next = out_month_reg;
        out_year_next  = out_year_reg;
        out_ovf_next   = out_ovf_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        loop_cond      = 1'b0;

        case (uw.op)
            OP_LOAD: begin
                if (s_accept) begin
                    day_next   = {1'b0, s_tdata[4:0]};
                    month_next = {1'b0, s_tdata[8:5]};
                    year_next  = {3'd0, s_tdata[22:9]};
                    amt_next   = s_tdata[38:23];
                end
            end
            OP_YMUL, OP_AMUL: begin
                prod_next = mul_a * mul_b;
            end
            OP_YMOD: begin
                yr400_next = yr_rem[8:0];
            end
            OP_YSTEP: begin
                loop_cond = year_fits;
                if (year_fits) begin
                    amt_next   = amt_reg - {7'd0, year_len};
                    year_next  = year_reg + 17'd1;
                    yr400_next = yr400_inc;
                end
            end
            OP_MSTEP: begin
                loop_cond = month_fits;
                if (month_fits) begin
                    amt_next = amt_reg - {11'd0, cur_mlen};
                    if (month_wrap) begin
                        month_next = 5'd1;
                        year_next  = year_reg + 17'd1;
                        yr400_next = yr400_inc;
                    end else begin
                        month_next = month_reg + 5'd1;
                    end
                end
            end
            OP_DAYADD: begin
                day_next = day_reg + {1'b0, amt_reg[4:0]};
            end
            OP_DAYFIX: begin
                if (day_reg > {1'b0, cur_mlen}) begin
                    day_next = day_reg - {1'b0, cur_mlen};
                    if (month_wrap) begin
                        month_next = 5'd1;
                        year_next  = year_reg + 17'd1;
                        yr400_next = yr400_inc;
                    end else begin
                        month_next = month_reg + 5'd1;
                    end
                end
            end
            OP_MADD: begin
                year_next  = year_reg + {4'd0, q12};
                month_next = month_reg + {1'b0, mon_rem[3:0]};
            end
            OP_MFIX: begin
                if (month_reg > MONTHS_PER_YEAR) begin
                    month_next = month_reg - MONTHS_PER_YEAR;
                    year_next  = year_reg + 17'd1;
                end
            end
            OP_YADD: begin
                year_next = year_reg + {1'b0, amt_reg};
            end
            OP_FINISH: begin
                if (out_free) begin
                    out_day_next   = day_reg[4:0];
                    out_month_next = month_reg[3:0];
                    out_year_next  = sat ? YEAR_MAX : year_reg[13:0];
                    out_ovf_next   = sat;
                    m_tvalid_next  = 1'b1;
                end
            end
            default: begin
            end
        endcase

        case (uw.seq)
            SEQ_NEXT:     pc_next = pc_reg + 4'd1;
            SEQ_JUMP:     pc_next = uw.target;
            SEQ_WAIT_IN:  pc_next = s_accept ? dispatch(action_t'(s_tuser)) : pc_reg;
            SEQ_LOOP:     pc_next = loop_cond ? pc_reg : pc_reg + 4'd1;
            SEQ_WAIT_OUT: pc_next = out_free ? uw.target : pc_reg;
            default:      pc_next = P_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= P_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        year_reg      <= year_next;
        month_reg     <= month_next;
        day_reg       <= day_next;
        amt_reg       <= amt_next;
        yr400_reg     <= yr400_next;
        prod_reg      <= prod_next;
        out_day_reg   <= out_day_next;
        out_month_reg <= out_month_next;
        out_year_reg  <= out_year_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {1'b0, out_year_reg, out_month_reg, out_day_reg};
    assign m_tuser[0] = out_ovf_reg;

`ifndef SYNTHESIS
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> pc_reg != P_IDLE)
        else $error("sequencer stayed idle after an input transfer");

    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= P_DONE)
        else $error("step counter outside the microcode program");

    a_yr400_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == P_DYEAR || pc_reg == P_DMON || pc_reg == P_DFIX) |-> yr400_reg < LEAP_CYCLE)
        else $error("year residue modulo 400 out of range");

    a_year_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> out_year_reg <= YEAR_MAX)
        else $error("result year above the saturation limit");

    a_ovf_year: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_ovf_reg) |-> out_year_reg == YEAR_MAX)
        else $error("overflow flag set with an unsaturated year");
`endif

endmodule

### bench/tb_top.sv
// Testbench for the calendar date adder: random and directed date requests checked in order.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_CYCLES = 250;

    typedef struct {
        cda_pkg::action_t act;
        logic [4:0]       day;
        logic [3:0]       mon;
        logic [13:0]      yr;
        logic [15:0]      amt;
        int               gap;
        bit               drain;
    } date_req_t;

    typedef struct {
        logic [4:0]  day;
        logic [3:0]  mon;
        logic [13:0] yr;
        logic        ovf;
    } date_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    date_req_t req_q[$];
    date_res_t date_q[$];
    date_req_t cur_req;
    int        n_items;
    int        sent;
    int        gap_left;
    int        rx_count;
    int        stall_left;
    int        hold_cnt;
    int        errors = 0;
    int        cycles = 0;

    calendar_date_adder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit greg_leap(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned mdays(int unsigned m, int unsigned y);
        case (m)
            2:              return greg_leap(y) ? 29 : 28;
            4, 6, 9, 11:    return 30;
            default:        return 31;
        endcase
    endfunction

    function automatic void step_month(inout int unsigned m, inout int unsigned y);
        if (m >= 12) begin
            m = 1;
            y = y + 1;
        end else begin
            m = m + 1;
        end
    endfunction

    function automatic date_res_t add_to_date(date_req_t r);
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned rest;
        date_res_t   res;
        d = r.day;
        m = r.mon;
        y = r.yr;
        rest = r.amt;
        case (r.act)
            cda_pkg::ACT_DAYS: begin
                while (rest >= (greg_leap(y + 1) ? 366 : 365)) begin
                    rest = rest - (greg_leap(y + 1) ? 366 : 365);
                    y = y + 1;
                end
                while (rest >= mdays(m, y)) begin
                    rest = rest - mdays(m, y);
                    step_month(m, y);
                end
                d = d + rest;
                if (d > mdays(m, y)) begin
                    d = d - mdays(m, y);
                    step_month(m, y);
                end
            end
            cda_pkg::ACT_MONTHS: begin
                y = y + r.amt / 12;
                m = m + r.amt % 12;
                if (m > 12) begin
                    m = m - 12;
                    y = y + 1;
                end
            end
            cda_pkg::ACT_YEARS: begin
                y = y + r.amt;
            end
            default: begin
            end
        endcase
        res.ovf = (y > cda_pkg::YEAR_MAX);
        if (res.ovf) begin
            y = cda_pkg::YEAR_MAX;
        end
        res.day = d[4:0];
        res.mon = m[3:0];
        res.yr = y[13:0];
        return res;
    endfunction

    function automatic date_req_t mk_req(cda_pkg::action_t act, int unsigned day,
                                         int unsigned mon, int unsigned yr, int unsigned amt);
        date_req_t r;
        r.act = act;
        r.day = day[4:0];
        r.mon = mon[3:0];
        r.yr = yr[13:0];
        r.amt = amt[15:0];
        r.gap = $urandom_range(0, 11);
        r.drain = 1'b0;
        return r;
    endfunction

    function automatic date_req_t random_req(int idx);
        date_req_t   r;
        int unsigned yr;
        int unsigned mon;
        int unsigned sel;
        int unsigned amt;
        cda_pkg::action_t act;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            r = mk_req(cda_pkg::action_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                       $urandom_range(0, 15), $urandom_range(0, 16383), $urandom_range(0, 65535));
        end else begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                yr = $urandom_range(1, 9999);
            end else if (sel < 85) begin
                yr = $urandom_range(1896, 2104);
            end else begin
                yr = $urandom_range(9800, 9999);
            end
            mon = $urandom_range(1, 12);
            act = cda_pkg::action_t'($urandom_range(0, 2));
            sel = $urandom_range(0, 99);
            case (act)
                cda_pkg::ACT_DAYS: begin
                    if (sel < 60) begin
                        amt = $urandom_range(0, 400);
                    end else if (sel < 85) begin
                        amt = $urandom_range(0, 5000);
                    end else if (sel < 95) begin
                        amt = $urandom_range(0, 65535);
                    end else begin
                        amt = $urandom_range(60000, 65535);
                    end
                end
                cda_pkg::ACT_MONTHS: begin
                    amt = (sel < 80) ? $urandom_range(0, 300) : $urandom_range(0, 65535);
                end
                default: begin
                    if (sel < 70) begin
                        amt = $urandom_range(0, 50);
                    end else if (sel < 90) begin
                        amt = (9999 - yr) + $urandom_range(0, 2) - 1;
                    end else begin
                        amt = $urandom_range(0, 65535);
                    end
                end
            endcase
            r = mk_req(act, $urandom_range(1, mdays(mon, yr)), mon, yr, amt);
        end
        if (idx >= 1200 && idx < 1350) begin
            r.gap = 0;
        end
        r.drain = (idx == 30 || idx == 900);
        return r;
    endfunction

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        bit offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
            sent = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                date_q.push_back(add_to_date(cur_req));
                sent++;
                gap_left = cur_req.gap;
            end
            if (!s_tvalid || s_tready) begin
                offer = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (req_q.size() > 0 && !(req_q[0].drain && date_q.size() != 0)) begin
                    cur_req = req_q.pop_front();
                    offer = 1'b1;
                end
                s_tvalid <= offer;
                if (offer) begin
                    s_tdata <= {1'b0, cur_req.amt, cur_req.yr, cur_req.mon, cur_req.day};
                    s_tuser <= cur_req.act;
                end
            end
        end
    end

    always @(posedge aclk) begin
        date_res_t e;
        bit rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_count = 0;
            stall_left = 0;
            hold_cnt = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (date_q.size() == 0) begin
                    errors++;
                    $error("result transfer with no expected date waiting");
                end else begin
                    e = date_q.pop_front();
                    check_field("new_day", e.day, m_tdata[4:0]);
                    check_field("new_month", e.mon, m_tdata[8:5]);
                    check_field("new_year", e.yr, m_tdata[22:9]);
                    check_field("year_overflow", e.ovf, m_tuser[0]);
                end
                rx_count++;
                stall_left = (rx_count >= 1200 && rx_count < 1400) ? 0 : $urandom_range(0, 11);
                if (rx_count == 400) begin
                    hold_cnt = 400;
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int i;
        // Boundary amounts and dates for adding days.
        req_q.push_back(mk_req(cda_pkg::ACT_DAYS, 1, 1, 1, 0));
        req_q.push_back(mk_req(cda_pkg::ACT_DAYS, 1, 1, 1, 65535));
        req_q.push_back(mk_req(cda_pkg::ACT_DAYS, 31, 12, 9999, 65535));
        req_q.push_back(mk_req(cda_pkg::ACT_DAYS, 1, 1, 1999, 365));
        req_q.push_back(mk_req(cda_pkg::ACT_DAYS, 28, 2, 1999, 366));
        req_q.push_back(mk_req(cda_pkg::ACT_DAYS, 31, 12, 2023, 1));
        req_q.push_back(mk_req(cda_pkg::ACT_DAYS, 31, 1, 2023, 30));
        req_q.push_back(mk_req(cda_pkg::ACT_DAYS, 29, 2, 2000, 1));
        req_q.push_back(mk_req(cda_pkg::ACT_DAYS, 15, 0, 2020, 40));
        req_q.push_back(mk_req(cda_pkg::ACT_DAYS, 15, 13, 2020, 10));
        req_q.push_back(mk_req(cda_pkg::ACT_DAYS, 31, 15, 2020, 40));
        req_q.push_back(mk_req(cda_pkg::ACT_DAYS, 0, 5, 2020, 0));
        req_q.push_back(mk_req(cda_pkg::ACT_DAYS, 10, 3, 0, 400));
        req_q.push_back(mk_req(cda_pkg::ACT_DAYS, 31, 15, 16383, 65535));
        // Month carries, including a month outside the calendar.
        req_q.push_back(mk_req(cda_pkg::ACT_MONTHS, 31, 1, 1, 0));
        req_q.push_back(mk_req(cda_pkg::ACT_MONTHS, 31, 12, 2021, 11));
        req_q.push_back(mk_req(cda_pkg::ACT_MONTHS, 1, 1, 1, 65535));
        req_q.push_back(mk_req(cda_pkg::ACT_MONTHS, 3, 15, 100, 5));
        req_q.push_back(mk_req(cda_pkg::ACT_MONTHS, 3, 0, 100, 7));
        // Year adds around saturation, then the unused action code.
        req_q.push_back(mk_req(cda_pkg::ACT_YEARS, 1, 1, 1, 0));
        req_q.push_back(mk_req(cda_pkg::ACT_YEARS, 5, 6, 1, 9998));
        req_q.push_back(mk_req(cda_pkg::ACT_YEARS, 5, 6, 9999, 1));
        req_q.push_back(mk_req(cda_pkg::ACT_YEARS, 31, 15, 16383, 65535));
        req_q.push_back(mk_req(cda_pkg::ACT_NONE, 17, 8, 12000, 1234));
        req_q.push_back(mk_req(cda_pkg::ACT_NONE, 17, 8, 2024, 65535));
        for (i = 0; i < 1550; i++) begin
            req_q.push_back(random_req(i));
        end
        n_items = req_q.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(sent == n_items && date_q.size() == 0)) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && date_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
design/cda_pkg.sv
design/calendar_date_adder.sv
bench/tb_top.sv
